FILE: rtl/prg_pkg.sv
// Shared types, constants and helpers for the pool resize governor.
package prg_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_POOLS_DEF = 8;
    localparam int SIZE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF = 48;

    // Fixed field widths
    localparam int POOL_ID_W  = 3;
    localparam int CHANGE_W   = 13;
    localparam int COOLDOWN_W = 32;
    localparam int CNT_W      = 32;
    localparam int SHRUNK_W   = 4;
    localparam int OUTCOME_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register reset values, truncated to SIZE_BITS where used
    localparam int MIN_SIZE_RESET = 1;
    localparam int MAX_SIZE_RESET = 4095;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SIZE    = 2'd0,
        CFG_MAX_SIZE    = 2'd1,
        CFG_DEFAULT_CD  = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    // Request codes
    typedef enum logic {
        FUNC_DELTA  = 1'b0,
        FUNC_SHRINK = 1'b1
    } t_func;

    // Result codes
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_RESIZED   = 2'd0,
        OUT_THROTTLED = 2'd1,
        OUT_REJECTED  = 2'd2,
        OUT_SHRUNK    = 2'd3
    } t_outcome;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT,
        ST_WALK,
        ST_FINISH
    } t_state;

    // Table port controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctl;

    // Counter increment that holds at all ones
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

FILE: rtl/prg_table.sv
// Pool record memory: one write port, one read port with registered data.
module prg_table #(
    parameter int DEPTH  = prg_pkg::NUM_POOLS_DEF,
    parameter int ADDR_W = 3,
    parameter int REC_W  = 168
) (
    input  logic                  i_clk,
    input  prg_pkg::t_tbl_ctl     i_ctl,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [REC_W-1:0]      i_wr_data,
    output logic [REC_W-1:0]      o_rd_data
);

    logic [REC_W-1:0] r_mem [DEPTH];
    logic [REC_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/prg_seq.sv
// Request sequencer: read-modify-write of pool records, shrink walk, result register.
module prg_seq #(
    parameter int NUM_POOLS = prg_pkg::NUM_POOLS_DEF,
    parameter int SIZE_BITS = prg_pkg::SIZE_BITS_DEF,
    parameter int TIME_BITS = prg_pkg::TIME_BITS_DEF,
    parameter int PW        = 3,
    parameter int REC_W     = 168
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration values
    input  logic [SIZE_BITS-1:0]                  i_floor_size,
    input  logic [SIZE_BITS-1:0]                  i_cap_size,
    input  logic [prg_pkg::COOLDOWN_W-1:0]        i_default_cd,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_func,
    input  logic [prg_pkg::POOL_ID_W-1:0]         i_pool_id,
    input  logic signed [prg_pkg::CHANGE_W-1:0]   i_size_change,
    input  logic [prg_pkg::COOLDOWN_W-1:0]        i_cooldown_override,
    input  logic [TIME_BITS-1:0]                  i_now_time,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [prg_pkg::OUTCOME_W-1:0]         o_outcome,
    output logic [SIZE_BITS-1:0]                  o_pool_size_now,
    output logic [prg_pkg::SHRUNK_W-1:0]          o_shrunk_count,
    output logic [prg_pkg::CNT_W-1:0]             o_throttled_total,
    output logic [prg_pkg::CNT_W-1:0]             o_rejected_total,
    output logic [prg_pkg::CNT_W-1:0]             o_resize_total,
    // table port
    output prg_pkg::t_tbl_ctl                     o_tbl_ctl,
    output logic [PW-1:0]                         o_rd_addr,
    output logic [PW-1:0]                         o_wr_addr,
    output logic [REC_W-1:0]                      o_wr_data,
    input  logic [REC_W-1:0]                      i_rd_data
);

    localparam int CNT_W   = prg_pkg::CNT_W;
    localparam int CD_W    = prg_pkg::COOLDOWN_W;
    localparam int CH_W    = prg_pkg::CHANGE_W;
    localparam int ID_W    = prg_pkg::POOL_ID_W;
    localparam int ID_SPAN = 1 << ID_W;
    // record layout: {thr, rej, res, stamp, size}
    localparam int SIZE_LO  = 0;
    localparam int STAMP_LO = SIZE_BITS;
    localparam int RES_LO   = SIZE_BITS + TIME_BITS;
    localparam int REJ_LO   = RES_LO + CNT_W;
    localparam int THR_LO   = REJ_LO + CNT_W;
    // signed sum width for the clamp
    localparam int BASE_W  = (SIZE_BITS + 1 > CH_W) ? SIZE_BITS + 1 : CH_W;
    localparam int AW      = BASE_W + 1;
    localparam int CMP_W   = (TIME_BITS > CD_W) ? TIME_BITS : CD_W;
    localparam logic [PW-1:0] LAST_POOL = PW'(NUM_POOLS - 1);

    // pool_id modulo the pool count, by repeated subtraction on a narrow value
    function automatic logic [PW-1:0] pool_index(input logic [ID_W-1:0] pid);
        logic [ID_W:0] v;
        v = {1'b0, pid};
        if (NUM_POOLS < ID_SPAN) begin
            for (int k = 0; k < ID_SPAN; k++) begin
                if (v >= (ID_W+1)'(NUM_POOLS)) begin
                    v = v - (ID_W+1)'(NUM_POOLS);
                end
            end
        end
        return PW'(v);
    endfunction

    prg_pkg::t_state r_state, n_state;

    // request latches
    logic [PW-1:0]            r_pidx;
    logic signed [CH_W-1:0]   r_change;
    logic [CD_W-1:0]          r_cd;
    logic [TIME_BITS-1:0]     r_now;
    // evaluation stage
    logic [TIME_BITS-1:0]     r_elapsed;
    logic [SIZE_BITS-1:0]     r_target;
    logic [SIZE_BITS-1:0]     r_cur;
    logic [prg_pkg::SHRUNK_W-1:0] r_shrunk;
    // per-pool valid bits: size/stamp written, counters written
    logic [NUM_POOLS-1:0]     r_touched;
    logic [NUM_POOLS-1:0]     r_cvalid;
    // result register
    logic                     r_o_valid;
    prg_pkg::t_outcome        r_o_outcome;
    logic [SIZE_BITS-1:0]     r_o_size;
    logic [prg_pkg::SHRUNK_W-1:0] r_o_shrunk;
    logic [CNT_W-1:0]         r_o_thr;
    logic [CNT_W-1:0]         r_o_rej;
    logic [CNT_W-1:0]         r_o_res;

    logic in_fire, out_free, walk_last, commit_fire, finish_fire, walk_shrink;

    // record fields as read
    logic [SIZE_BITS-1:0] rd_size;
    logic [TIME_BITS-1:0] rd_stamp;
    logic [CNT_W-1:0]     rd_thr, rd_rej, rd_res;
    logic                 touched_p;
    logic [CNT_W-1:0]     thr_m, rej_m, res_m;
    logic [SIZE_BITS-1:0] cur;

    // clamp arithmetic
    logic signed [AW-1:0] cur_s, ch_s, min_s, max_s, sum_s, lo_s, clamp_s;

    // commit decision
    logic                 throttle, same, resize;
    logic [CNT_W-1:0]     new_thr, new_rej, new_res;
    logic [SIZE_BITS-1:0] new_size;
    logic [TIME_BITS-1:0] new_stamp;
    prg_pkg::t_outcome    commit_outcome;

    assign rd_size  = i_rd_data[SIZE_LO  +: SIZE_BITS];
    assign rd_stamp = i_rd_data[STAMP_LO +: TIME_BITS];
    assign rd_res   = i_rd_data[RES_LO   +: CNT_W];
    assign rd_rej   = i_rd_data[REJ_LO   +: CNT_W];
    assign rd_thr   = i_rd_data[THR_LO   +: CNT_W];

    assign touched_p = r_touched[r_pidx];
    assign thr_m = r_cvalid[r_pidx] ? rd_thr : '0;
    assign rej_m = r_cvalid[r_pidx] ? rd_rej : '0;
    assign res_m = r_cvalid[r_pidx] ? rd_res : '0;
    assign cur   = touched_p ? rd_size : i_floor_size;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !r_o_valid || i_out_ready;
    assign walk_last = (r_pidx == LAST_POOL);

    // add the signed change and clamp: below by min, then above by max
    always_comb begin
        cur_s   = $signed({{(AW-SIZE_BITS){1'b0}}, cur});
        ch_s    = $signed({{(AW-CH_W){r_change[CH_W-1]}}, r_change});
        min_s   = $signed({{(AW-SIZE_BITS){1'b0}}, i_floor_size});
        max_s   = $signed({{(AW-SIZE_BITS){1'b0}}, i_cap_size});
        sum_s   = cur_s + ch_s;
        lo_s    = (sum_s < min_s) ? min_s : sum_s;
        clamp_s = (lo_s > max_s) ? max_s : lo_s;
    end

    // throttle check and counter updates for a delta request
    always_comb begin
        throttle = (r_cd != '0) && touched_p &&
                   (CMP_W'(r_elapsed) < CMP_W'(r_cd));
        same     = (r_target == r_cur);
        resize   = !throttle && !same;
        new_thr  = throttle ? prg_pkg::sat_inc(thr_m) : thr_m;
        new_rej  = (!throttle && same) ? prg_pkg::sat_inc(rej_m) : rej_m;
        new_res  = resize ? prg_pkg::sat_inc(res_m) : res_m;
        new_size  = resize ? r_target : r_cur;
        new_stamp = resize ? r_now : rd_stamp;
        if (throttle) begin
            commit_outcome = prg_pkg::OUT_THROTTLED;
        end else if (same) begin
            commit_outcome = prg_pkg::OUT_REJECTED;
        end else begin
            commit_outcome = prg_pkg::OUT_RESIZED;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prg_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = (i_func == prg_pkg::FUNC_SHRINK) ? prg_pkg::ST_WALK
                                                               : prg_pkg::ST_EVAL;
                end
            end
            prg_pkg::ST_EVAL:   n_state = prg_pkg::ST_COMMIT;
            prg_pkg::ST_COMMIT: if (out_free) n_state = prg_pkg::ST_IDLE;
            prg_pkg::ST_WALK:   if (walk_last) n_state = prg_pkg::ST_FINISH;
            prg_pkg::ST_FINISH: if (out_free) n_state = prg_pkg::ST_IDLE;
            default:            n_state = prg_pkg::ST_IDLE;
        endcase
    end

    // state outputs: handshake and table port controls
    always_comb begin
        o_in_ready      = 1'b0;
        o_tbl_ctl.rd_en = 1'b0;
        o_tbl_ctl.wr_en = 1'b0;
        o_rd_addr       = '0;
        commit_fire     = 1'b0;
        finish_fire     = 1'b0;
        walk_shrink     = 1'b0;
        unique case (r_state)
            prg_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_tbl_ctl.rd_en = i_in_valid;
                o_rd_addr       = (i_func == prg_pkg::FUNC_SHRINK) ? '0
                                                                   : pool_index(i_pool_id);
            end
            prg_pkg::ST_EVAL: begin
            end
            prg_pkg::ST_COMMIT: begin
                commit_fire     = out_free;
                o_tbl_ctl.wr_en = out_free;
            end
            prg_pkg::ST_WALK: begin
                walk_shrink     = touched_p && (rd_size > i_floor_size);
                o_tbl_ctl.wr_en = walk_shrink;
                o_tbl_ctl.rd_en = !walk_last;
                o_rd_addr       = PW'(r_pidx + PW'(1));
            end
            prg_pkg::ST_FINISH: begin
                finish_fire = out_free;
            end
            default: begin
            end
        endcase
    end

    // write back to the pool being worked on
    assign o_wr_addr = r_pidx;
    assign o_wr_data = (r_state == prg_pkg::ST_WALK)
                     ? {thr_m, rej_m, prg_pkg::sat_inc(res_m), r_now, i_floor_size}
                     : {new_thr, new_rej, new_res, new_stamp, new_size};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= prg_pkg::ST_IDLE;
            r_touched <= '0;
            r_cvalid  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit_fire) begin
                r_cvalid[r_pidx] <= 1'b1;
                if (resize) begin
                    r_touched[r_pidx] <= 1'b1;
                end
            end
            if (walk_shrink) begin
                r_cvalid[r_pidx]  <= 1'b1;
                r_touched[r_pidx] <= 1'b1;
            end
            if (commit_fire || finish_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // request latches, evaluation stage, walk pointer
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pidx   <= (i_func == prg_pkg::FUNC_SHRINK) ? '0 : pool_index(i_pool_id);
            r_change <= i_size_change;
            r_cd     <= (i_cooldown_override == '0) ? i_default_cd : i_cooldown_override;
            r_now    <= i_now_time;
            r_shrunk <= '0;
        end
        if (r_state == prg_pkg::ST_EVAL) begin
            r_elapsed <= r_now - rd_stamp;
            r_target  <= clamp_s[SIZE_BITS-1:0];
            r_cur     <= cur;
        end
        if (r_state == prg_pkg::ST_WALK) begin
            if (!walk_last) begin
                r_pidx <= PW'(r_pidx + PW'(1));
            end
            if (walk_shrink && (r_shrunk != '1)) begin
                r_shrunk <= r_shrunk + prg_pkg::SHRUNK_W'(1);
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (commit_fire) begin
            r_o_outcome <= commit_outcome;
            r_o_size    <= new_size;
            r_o_shrunk  <= '0;
            r_o_thr     <= new_thr;
            r_o_rej     <= new_rej;
            r_o_res     <= new_res;
        end else if (finish_fire) begin
            r_o_outcome <= prg_pkg::OUT_SHRUNK;
            r_o_size    <= '0;
            r_o_shrunk  <= r_shrunk;
            r_o_thr     <= '0;
            r_o_rej     <= '0;
            r_o_res     <= '0;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_outcome         = r_o_outcome;
    assign o_pool_size_now   = r_o_size;
    assign o_shrunk_count    = r_o_shrunk;
    assign o_throttled_total = r_o_thr;
    assign o_rejected_total  = r_o_rej;
    assign o_resize_total    = r_o_res;

endmodule

FILE: rtl/pool_resize_governor_unit.sv
// Top level of the pool resize governor: configuration registers, sequencer and pool table.
// A delta request first reads its pool record from the table as it is transferred,
// then forms the clamped size and the elapsed time, and then decides, writes the
// record back and loads the result. The next request is taken in the cycle after
// that, so the unit takes no new request before it is through with the last one.
// A shrink-all request walks the table through its single read and write port,
// one pool per cycle, and loads its result in the finish step after the last pool.
// A result waiting at the output stalls only the final step of the request that
// follows it. No clearing pass follows reset; configuration writes are taken in
// every cycle and should be made only while no request is in flight.
module pool_resize_governor_unit #(
    parameter int NUM_POOLS = prg_pkg::NUM_POOLS_DEF,
    parameter int SIZE_BITS = prg_pkg::SIZE_BITS_DEF,
    parameter int TIME_BITS = prg_pkg::TIME_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [prg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [prg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_func,
    input  logic [prg_pkg::POOL_ID_W-1:0]         i_pool_id,
    input  logic signed [prg_pkg::CHANGE_W-1:0]   i_size_change,
    input  logic [prg_pkg::COOLDOWN_W-1:0]        i_cooldown_override,
    input  logic [TIME_BITS-1:0]                  i_now_time,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [prg_pkg::OUTCOME_W-1:0]         o_outcome,
    output logic [SIZE_BITS-1:0]                  o_pool_size_now,
    output logic [prg_pkg::SHRUNK_W-1:0]          o_shrunk_count,
    output logic [prg_pkg::CNT_W-1:0]             o_throttled_total,
    output logic [prg_pkg::CNT_W-1:0]             o_rejected_total,
    output logic [prg_pkg::CNT_W-1:0]             o_resize_total
);

    localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int REC_W = SIZE_BITS + TIME_BITS + 3 * prg_pkg::CNT_W;

    logic [SIZE_BITS-1:0]              r_floor_size;
    logic [SIZE_BITS-1:0]              r_cap_size;
    logic [prg_pkg::COOLDOWN_W-1:0]    r_default_cd;

    prg_pkg::t_tbl_ctl  tbl_ctl;
    logic [PW-1:0]      rd_addr, wr_addr;
    logic [REC_W-1:0]   wr_data, rd_data;

    assign o_cfg_ready = 1'b1;

    // configuration registers; sizes keep their low SIZE_BITS
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_size <= SIZE_BITS'(prg_pkg::MIN_SIZE_RESET);
            r_cap_size   <= SIZE_BITS'(prg_pkg::MAX_SIZE_RESET);
            r_default_cd <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prg_pkg::CFG_MIN_SIZE:   r_floor_size <= i_cfg_data[SIZE_BITS-1:0];
                prg_pkg::CFG_MAX_SIZE:   r_cap_size   <= i_cfg_data[SIZE_BITS-1:0];
                prg_pkg::CFG_DEFAULT_CD: r_default_cd <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    prg_seq #(
        .NUM_POOLS (NUM_POOLS),
        .SIZE_BITS (SIZE_BITS),
        .TIME_BITS (TIME_BITS),
        .PW        (PW),
        .REC_W     (REC_W)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_floor_size        (r_floor_size),
        .i_cap_size          (r_cap_size),
        .i_default_cd        (r_default_cd),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_pool_id           (i_pool_id),
        .i_size_change       (i_size_change),
        .i_cooldown_override (i_cooldown_override),
        .i_now_time          (i_now_time),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_outcome           (o_outcome),
        .o_pool_size_now     (o_pool_size_now),
        .o_shrunk_count      (o_shrunk_count),
        .o_throttled_total   (o_throttled_total),
        .o_rejected_total    (o_rejected_total),
        .o_resize_total      (o_resize_total),
        .o_tbl_ctl           (tbl_ctl),
        .o_rd_addr           (rd_addr),
        .o_wr_addr           (wr_addr),
        .o_wr_data           (wr_data),
        .i_rd_data           (rd_data)
    );

    prg_table #(
        .DEPTH  (NUM_POOLS),
        .ADDR_W (PW),
        .REC_W  (REC_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_ctl     (tbl_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

FILE: rtl/prg_checker.sv
// Port-level checks for the pool resize governor, bound to the top level.
module prg_checker #(
    parameter int SIZE_BITS = prg_pkg::SIZE_BITS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [prg_pkg::OUTCOME_W-1:0]   o_outcome,
    input logic [SIZE_BITS-1:0]            o_pool_size_now,
    input logic [prg_pkg::SHRUNK_W-1:0]    o_shrunk_count,
    input logic [prg_pkg::CNT_W-1:0]       o_throttled_total,
    input logic [prg_pkg::CNT_W-1:0]       o_rejected_total,
    input logic [prg_pkg::CNT_W-1:0]       o_resize_total
);

    // a stalled result stays put: valid, outcome, pool size, shrink count, resize total
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_outcome) && $stable(o_pool_size_now) &&
            $stable(o_shrunk_count) && $stable(o_resize_total))
        else $error("result changed while stalled");

    // one request at a time: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in flight");

    // shrink-all results carry no pool size or counters
    a_shrink_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == prg_pkg::OUT_SHRUNK) |->
            (o_pool_size_now == '0) && (o_throttled_total == '0) &&
            (o_rejected_total == '0) && (o_resize_total == '0))
        else $error("shrink-all result has nonzero pool fields");

    // delta results carry no shrink count
    a_delta_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome != prg_pkg::OUT_SHRUNK) |-> (o_shrunk_count == '0))
        else $error("delta result has nonzero shrink count");

endmodule

bind pool_resize_governor_unit prg_checker #(
    .SIZE_BITS (SIZE_BITS)
) u_prg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_outcome         (o_outcome),
    .o_pool_size_now   (o_pool_size_now),
    .o_shrunk_count    (o_shrunk_count),
    .o_throttled_total (o_throttled_total),
    .o_rejected_total  (o_rejected_total),
    .o_resize_total    (o_resize_total)
);
